FILE: hdl/cse_pkg.sv
`timescale 1ns / 1ps
package cse_pkg;

   // Register file indexes: B, C, D, E, H, L, A.
   localparam logic [2:0] RB = 3'd0;
   localparam logic [2:0] RC = 3'd1;
   localparam logic [2:0] RD = 3'd2;
   localparam logic [2:0] RE = 3'd3;
   localparam logic [2:0] RH = 3'd4;
   localparam logic [2:0] RL = 3'd5;
   localparam logic [2:0] RA = 3'd6;

   // Register field code that selects memory at HL.
   localparam logic [2:0] CODE_M = 3'd6;

   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_HLT  = 8'h76;
   localparam logic [7:0] OP_ADI  = 8'hC6;
   localparam logic [7:0] OP_ACI  = 8'hCE;
   localparam logic [7:0] OP_SUI  = 8'hD6;
   localparam logic [7:0] OP_SBI  = 8'hDE;
   localparam logic [7:0] OP_LXIB = 8'h01;
   localparam logic [7:0] OP_LXID = 8'h11;
   localparam logic [7:0] OP_LXIH = 8'h21;
   localparam logic [7:0] OP_LXIS = 8'h31;
   localparam logic [7:0] OP_LDXB = 8'h0A;
   localparam logic [7:0] OP_LDXD = 8'h1A;
   localparam logic [7:0] OP_LDA  = 8'h3A;
   localparam logic [7:0] OP_STXB = 8'h02;
   localparam logic [7:0] OP_STXD = 8'h12;
   localparam logic [7:0] OP_STA  = 8'h32;
   localparam logic [7:0] OP_LHLD = 8'h2A;
   localparam logic [7:0] OP_SHLD = 8'h22;
   localparam logic [7:0] OP_XCHG = 8'hEB;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UNIMPL = 2'd1;
   localparam logic [1:0] ST_HALTED = 2'd2;

   typedef struct packed {
      logic [7:0]  out_a;
      logic [7:0]  out_b;
      logic [7:0]  out_c;
      logic [7:0]  out_d;
      logic [7:0]  out_e;
      logic [7:0]  out_h;
      logic [7:0]  out_l;
      logic [4:0]  out_flags;
      logic [15:0] out_sp;
      logic [15:0] out_pc;
      logic [1:0]  status;
      logic [2:0]  cycle_cost;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] res;
      logic [4:0] flags;
   } alu_out_type;

   // Opcode register field to register file index (A sits at index 6).
   function automatic logic [2:0] reg_sel(input logic [2:0] code);
      reg_sel = (code == 3'd7) ? RA : code;
   endfunction

   // Flags are {S, Z, AC, P, CY}. Subtraction runs as A + ~b + !borrow.
   function automatic alu_out_type alu_fn(input logic [1:0] kind, input logic [7:0] a,
                                          input logic [7:0] b, input logic cy);
      logic       sub;
      logic [7:0] opnd;
      logic       cin;
      logic [8:0] sum;
      logic [4:0] lo;
      alu_out_type r;
      sub  = kind[1];
      opnd = sub ? ~b : b;
      cin  = sub ? (kind[0] ? ~cy : 1'b1) : (kind[0] ? cy : 1'b0);
      sum  = {1'b0, a} + {1'b0, opnd} + {8'd0, cin};
      lo   = {1'b0, a[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin};
      r.res   = sum[7:0];
      r.flags = {sum[7], (sum[7:0] == 8'd0), lo[4], ~^sum[7:0], sum[8] ^ sub};
      return r;
   endfunction

   function automatic alu_out_type inr_fn(input logic [7:0] v, input logic cy);
      alu_out_type r;
      r.res   = v + 8'd1;
      r.flags = {r.res[7], (r.res == 8'd0), (v[3:0] == 4'hF), ~^r.res, cy};
      return r;
   endfunction

   // Machine cycle cost of an opcode, zero when it is outside the subset.
   function automatic logic [2:0] cost_fn(input logic [7:0] op);
      logic [2:0] d;
      logic [2:0] s;
      logic [2:0] c;
      d = op[5:3];
      s = op[2:0];
      c = 3'd0;
      if (op[7:6] == 2'b01 && op != OP_HLT)
         c = (d == CODE_M || s == CODE_M) ? 3'd2 : 3'd1;
      else if (op[7:5] == 3'b100)
         c = (s == CODE_M) ? 3'd2 : 3'd1;
      else if (op[7:6] == 2'b00 && s == 3'd6)
         c = (d == CODE_M) ? 3'd3 : 3'd2;
      else if (op[7:6] == 2'b00 && s == 3'd4)
         c = (d == CODE_M) ? 3'd3 : 3'd1;
      else if (op == OP_NOP || op == OP_XCHG)
         c = 3'd1;
      else if (op == OP_ADI || op == OP_ACI || op == OP_SUI || op == OP_SBI)
         c = 3'd2;
      else if (op == OP_LXIB || op == OP_LXID || op == OP_LXIH || op == OP_LXIS)
         c = 3'd3;
      else if (op == OP_LDXB || op == OP_LDXD || op == OP_STXB || op == OP_STXD)
         c = 3'd2;
      else if (op == OP_LDA || op == OP_STA)
         c = 3'd4;
      else if (op == OP_LHLD || op == OP_SHLD)
         c = 3'd5;
      return c;
   endfunction

endpackage

FILE: hdl/cse_if.sv
`timescale 1ns / 1ps
interface cse_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] load_addr;
   logic [7:0]  load_data;
   modport source (output valid, output op, output load_addr, output load_data,
                   input ready);
   modport sink (input valid, input op, input load_addr, input load_data,
                 output ready);
endinterface

interface cse_rsp_if;
   logic                  valid;
   logic                  ready;
   cse_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

FILE: hdl/cpu8080_subset_execute_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Carries
// req_chan  in         op, load_addr, load_data
// rsp_chan  out        registers, flags, SP, PC, status, cycle_cost
//
// All memory traffic goes through one single-port RAM with a registered read. After
// reset the RAM is cleared one byte a cycle, all 2**ADDR_BITS bytes, before any word
// is accepted. The result register lets the next word be accepted and executed while
// the previous result still waits on rsp_chan.ready; the posting cycle stalls only
// while that register is still full.
module cpu8080_subset_execute_unit #(
   parameter int ADDR_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   cse_req_if.sink      req_chan,
   cse_rsp_if.source    rsp_chan
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_OPC, S_IMM1, S_IMM2, S_MRD, S_MRD2, S_MWR2, S_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [7:0]            regs_ff [7];
   logic [7:0]            regs_in [7];
   logic [4:0]            flags_ff, flags_in;
   logic [15:0]           sp_ff, sp_in;
   logic [15:0]           pc_ff, pc_in;
   logic                  halted_ff, halted_in;
   logic [7:0]            opcode_ff, opcode_in;
   logic [7:0]            imm_lo_ff, imm_lo_in;
   logic [15:0]           ad_ff, ad_in;
   logic [1:0]            status_ff, status_in;
   logic [2:0]            cost_ff, cost_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cse_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  ram_we;
   logic [15:0]           ram_addr16;
   logic [7:0]            ram_wdata;
   logic [7:0]            ram_rdata;

   logic [7:0]            op_cur;
   logic [2:0]            dst;
   logic [2:0]            src;
   logic [15:0]           hl;
   logic [15:0]           bc_de;
   logic [15:0]           imm16;
   logic [7:0]            src_val;
   cse_pkg::alu_out_type  alu_r;
   cse_pkg::alu_out_type  inr_r;
   logic                  is_mov, is_alu, is_mvi, is_inr, is_alui, is_two;

   cse_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_BITS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr16[ADDR_BITS-1:0]),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   // The opcode is taken straight from the RAM in the cycle it arrives.
   assign op_cur  = (state_ff == S_OPC) ? ram_rdata : opcode_ff;
   assign dst     = op_cur[5:3];
   assign src     = op_cur[2:0];
   assign hl      = {regs_ff[cse_pkg::RH], regs_ff[cse_pkg::RL]};
   assign bc_de   = op_cur[4] ? {regs_ff[cse_pkg::RD], regs_ff[cse_pkg::RE]}
                              : {regs_ff[cse_pkg::RB], regs_ff[cse_pkg::RC]};
   assign imm16   = {ram_rdata, imm_lo_ff};
   assign is_mov  = (op_cur[7:6] == 2'b01) && (op_cur != cse_pkg::OP_HLT);
   assign is_alu  = (op_cur[7:5] == 3'b100);
   assign is_mvi  = (op_cur[7:6] == 2'b00) && (src == 3'd6);
   assign is_inr  = (op_cur[7:6] == 2'b00) && (src == 3'd4);
   assign is_alui = (op_cur == cse_pkg::OP_ADI) || (op_cur == cse_pkg::OP_ACI) ||
                    (op_cur == cse_pkg::OP_SUI) || (op_cur == cse_pkg::OP_SBI);
   assign is_two  = (op_cur == cse_pkg::OP_LXIB) || (op_cur == cse_pkg::OP_LXID) ||
                    (op_cur == cse_pkg::OP_LXIH) || (op_cur == cse_pkg::OP_LXIS) ||
                    (op_cur == cse_pkg::OP_LDA) || (op_cur == cse_pkg::OP_STA) ||
                    (op_cur == cse_pkg::OP_LHLD) || (op_cur == cse_pkg::OP_SHLD);

   // In S_MRD and S_IMM1 the operand is the RAM byte (memory or immediate); elsewhere it is a register.
   always_comb begin
      if (state_ff == S_MRD || state_ff == S_IMM1) begin
         src_val = ram_rdata;
      end else begin
         src_val = regs_ff[cse_pkg::reg_sel(src)];
      end
   end

   assign alu_r = cse_pkg::alu_fn(op_cur[4:3], regs_ff[cse_pkg::RA], src_val, flags_ff[0]);
   assign inr_r = cse_pkg::inr_fn((state_ff == S_MRD) ? ram_rdata
                                  : regs_ff[cse_pkg::reg_sel(dst)], flags_ff[0]);

   always_comb begin
      state_in    = state_ff;
      regs_in     = regs_ff;
      flags_in    = flags_ff;
      sp_in       = sp_ff;
      pc_in       = pc_ff;
      halted_in   = halted_ff;
      opcode_in   = opcode_ff;
      imm_lo_in   = imm_lo_ff;
      ad_in       = ad_ff;
      status_in   = status_ff;
      cost_in     = cost_ff;
      clr_in      = clr_ff;
      ram_we      = 1'b0;
      ram_addr16  = pc_ff;
      ram_wdata   = regs_ff[cse_pkg::RA];
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in = rsp_word_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_addr16 = 16'(clr_ff);
            ram_wdata  = 8'd0;
            clr_in     = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            status_in = cse_pkg::ST_OK;
            cost_in   = 3'd0;
            if (req_chan.valid) begin
               if (!req_chan.op) begin
                  ram_we     = 1'b1;
                  ram_addr16 = req_chan.load_addr;
                  ram_wdata  = req_chan.load_data;
                  state_in   = S_RESP;
               end else if (halted_ff) begin
                  status_in = cse_pkg::ST_HALTED;
                  state_in  = S_RESP;
               end else begin
                  pc_in    = pc_ff + 16'd1;
                  state_in = S_OPC;
               end
            end
         end
         S_OPC: begin
            opcode_in = ram_rdata;
            cost_in   = cse_pkg::cost_fn(ram_rdata);
            state_in  = S_RESP;
            if (cse_pkg::cost_fn(ram_rdata) == 3'd0) begin
               pc_in     = pc_ff - 16'd1;
               halted_in = 1'b1;
               status_in = cse_pkg::ST_UNIMPL;
            end else if (is_mov) begin
               if (src == cse_pkg::CODE_M) begin
                  ram_addr16 = hl;
                  state_in   = S_MRD;
               end else if (dst == cse_pkg::CODE_M) begin
                  ram_we     = 1'b1;
                  ram_addr16 = hl;
                  ram_wdata  = src_val;
               end else begin
                  regs_in[cse_pkg::reg_sel(dst)] = src_val;
               end
            end else if (is_alu) begin
               if (src == cse_pkg::CODE_M) begin
                  ram_addr16 = hl;
                  state_in   = S_MRD;
               end else begin
                  regs_in[cse_pkg::RA] = alu_r.res;
                  flags_in             = alu_r.flags;
               end
            end else if (is_inr) begin
               if (dst == cse_pkg::CODE_M) begin
                  ram_addr16 = hl;
                  state_in   = S_MRD;
               end else begin
                  regs_in[cse_pkg::reg_sel(dst)] = inr_r.res;
                  flags_in                       = inr_r.flags;
               end
            end else if (op_cur == cse_pkg::OP_LDXB || op_cur == cse_pkg::OP_LDXD) begin
               ram_addr16 = bc_de;
               state_in   = S_MRD;
            end else if (op_cur == cse_pkg::OP_STXB || op_cur == cse_pkg::OP_STXD) begin
               ram_we     = 1'b1;
               ram_addr16 = bc_de;
            end else if (op_cur == cse_pkg::OP_XCHG) begin
               regs_in[cse_pkg::RH] = regs_ff[cse_pkg::RD];
               regs_in[cse_pkg::RL] = regs_ff[cse_pkg::RE];
               regs_in[cse_pkg::RD] = regs_ff[cse_pkg::RH];
               regs_in[cse_pkg::RE] = regs_ff[cse_pkg::RL];
            end else if (is_mvi || is_alui || is_two) begin
               pc_in    = pc_ff + 16'd1;
               state_in = S_IMM1;
            end
         end
         S_IMM1: begin
            state_in = S_RESP;
            if (is_mvi) begin
               if (dst == cse_pkg::CODE_M) begin
                  ram_we     = 1'b1;
                  ram_addr16 = hl;
                  ram_wdata  = ram_rdata;
               end else begin
                  regs_in[cse_pkg::reg_sel(dst)] = ram_rdata;
               end
            end else if (is_alui) begin
               regs_in[cse_pkg::RA] = alu_r.res;
               flags_in             = alu_r.flags;
            end else begin
               imm_lo_in = ram_rdata;
               pc_in     = pc_ff + 16'd1;
               state_in  = S_IMM2;
            end
         end
         S_IMM2: begin
            state_in = S_RESP;
            ad_in    = imm16 + 16'd1;
            priority case (1'b1)
               op_cur == cse_pkg::OP_LXIB: begin
                  regs_in[cse_pkg::RB] = ram_rdata;
                  regs_in[cse_pkg::RC] = imm_lo_ff;
               end
               op_cur == cse_pkg::OP_LXID: begin
                  regs_in[cse_pkg::RD] = ram_rdata;
                  regs_in[cse_pkg::RE] = imm_lo_ff;
               end
               op_cur == cse_pkg::OP_LXIH: begin
                  regs_in[cse_pkg::RH] = ram_rdata;
                  regs_in[cse_pkg::RL] = imm_lo_ff;
               end
               op_cur == cse_pkg::OP_LXIS: begin
                  sp_in = imm16;
               end
               op_cur == cse_pkg::OP_LDA || op_cur == cse_pkg::OP_LHLD: begin
                  ram_addr16 = imm16;
                  state_in   = S_MRD;
               end
               op_cur == cse_pkg::OP_STA: begin
                  ram_we     = 1'b1;
                  ram_addr16 = imm16;
               end
               default: begin
                  // SHLD: low byte now, high byte next cycle.
                  ram_we     = 1'b1;
                  ram_addr16 = imm16;
                  ram_wdata  = regs_ff[cse_pkg::RL];
                  state_in   = S_MWR2;
               end
            endcase
         end
         S_MRD: begin
            state_in = S_RESP;
            if (is_mov) begin
               regs_in[cse_pkg::reg_sel(dst)] = ram_rdata;
            end else if (is_alu) begin
               regs_in[cse_pkg::RA] = alu_r.res;
               flags_in             = alu_r.flags;
            end else if (is_inr) begin
               ram_we     = 1'b1;
               ram_addr16 = hl;
               ram_wdata  = inr_r.res;
               flags_in   = inr_r.flags;
            end else if (op_cur == cse_pkg::OP_LHLD) begin
               regs_in[cse_pkg::RL] = ram_rdata;
               ram_addr16           = ad_ff;
               state_in             = S_MRD2;
            end else begin
               regs_in[cse_pkg::RA] = ram_rdata;
            end
         end
         S_MRD2: begin
            regs_in[cse_pkg::RH] = ram_rdata;
            state_in             = S_RESP;
         end
         S_MWR2: begin
            ram_we     = 1'b1;
            ram_addr16 = ad_ff;
            ram_wdata  = regs_ff[cse_pkg::RH];
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.out_a      = regs_ff[cse_pkg::RA];
               rsp_word_in.out_b      = regs_ff[cse_pkg::RB];
               rsp_word_in.out_c      = regs_ff[cse_pkg::RC];
               rsp_word_in.out_d      = regs_ff[cse_pkg::RD];
               rsp_word_in.out_e      = regs_ff[cse_pkg::RE];
               rsp_word_in.out_h      = regs_ff[cse_pkg::RH];
               rsp_word_in.out_l      = regs_ff[cse_pkg::RL];
               rsp_word_in.out_flags  = flags_ff;
               rsp_word_in.out_sp     = sp_ff;
               rsp_word_in.out_pc     = pc_ff;
               rsp_word_in.status     = status_ff;
               rsp_word_in.cycle_cost = cost_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         regs_ff      <= '{default: 8'd0};
         flags_ff     <= 5'd0;
         sp_ff        <= 16'd0;
         pc_ff        <= 16'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         regs_ff      <= regs_in;
         flags_ff     <= flags_in;
         sp_ff        <= sp_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opcode_ff   <= opcode_in;
      imm_lo_ff   <= imm_lo_in;
      ad_ff       <= ad_in;
      status_ff   <= status_in;
      cost_ff     <= cost_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

FILE: hdl/cse_ram.sv
`timescale 1ns / 1ps
module cse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: tb/sv/tb_cpu8080_subset_execute_unit.sv
`timescale 1ns / 1ps
// Testbench for the 8080 subset execute unit.
// Each word on the request channel either stores one memory byte or runs one
// instruction at PC. A predictor inside this module keeps its own copy of the
// registers, flags, SP, PC, the halt bit and the full 64 KB memory. For every
// accepted word it computes the expected response word and queues it. Every
// response word is compared field by field with the oldest queued word.
module tb_cpu8080_subset_execute_unit;

   logic clock;
   logic reset;

   cse_req_if req_chan ();
   cse_rsp_if rsp_chan ();

   cpu8080_subset_execute_unit #(.ADDR_BITS(16)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predictor state. Register file indexes follow the package: B C D E H L A.
   logic [7:0]  cpu_regs [0:6];
   logic [4:0]  cpu_flags;
   logic [15:0] cpu_sp;
   logic [15:0] cpu_pc;
   logic        cpu_halted;
   logic [7:0]  cpu_mem [0:65535];

   // Response words that are still owed by the block, oldest first.
   cse_pkg::rsp_word_type pending_rsp [$];

   int fail_count;
   int words_sent;
   int words_checked;
   int halt_count;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The whole run is bounded. Beside the RAM clear after reset, about 450 words
   // with heavy stalls add little.
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [4:0] szp_flags(input logic [7:0] r);
      return {r[7], (r == 8'd0), 1'b0, ~^r, 1'b0};
   endfunction

   function automatic logic [15:0] reg_pair(input logic [2:0] hi, input logic [2:0] lo);
      return {cpu_regs[hi], cpu_regs[lo]};
   endfunction

   function automatic logic [7:0] read_operand(input logic [2:0] code);
      if (code == cse_pkg::CODE_M)
         return cpu_mem[reg_pair(cse_pkg::RH, cse_pkg::RL)];
      if (code == 3'd7)
         return cpu_regs[cse_pkg::RA];
      return cpu_regs[code];
   endfunction

   function automatic void write_operand(input logic [2:0] code, input logic [7:0] v);
      if (code == cse_pkg::CODE_M)
         cpu_mem[reg_pair(cse_pkg::RH, cse_pkg::RL)] = v;
      else if (code == 3'd7)
         cpu_regs[cse_pkg::RA] = v;
      else
         cpu_regs[code] = v;
   endfunction

   function automatic logic [7:0] fetch_byte();
      logic [7:0] v;
      v = cpu_mem[cpu_pc];
      cpu_pc = cpu_pc + 16'd1;
      return v;
   endfunction

   function automatic logic [15:0] fetch_word();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = fetch_byte();
      hi = fetch_byte();
      return {hi, lo};
   endfunction

   // Kind 0 ADD, 1 ADC, 2 SUB, 3 SBB. Subtraction adds the inverted operand
   // and the inverted borrow; CY then reports the borrow.
   function automatic void accumulate(input logic [1:0] kind, input logic [7:0] b);
      logic       sub;
      logic [7:0] opnd;
      logic       cin;
      logic [8:0] sum;
      logic [4:0] nib;
      logic [4:0] f;
      sub  = kind[1];
      opnd = sub ? ~b : b;
      cin  = kind[0] ? (cpu_flags[0] ^ sub) : sub;
      sum  = {1'b0, cpu_regs[cse_pkg::RA]} + {1'b0, opnd} + {8'd0, cin};
      nib  = {1'b0, cpu_regs[cse_pkg::RA][3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin};
      f    = szp_flags(sum[7:0]);
      f[2] = nib[4];
      f[0] = sum[8] ^ sub;
      cpu_flags = f;
      cpu_regs[cse_pkg::RA] = sum[7:0];
   endfunction

   // Runs one instruction on the predictor state; returns its cost, or zero
   // when the opcode lies outside the subset.
   function automatic logic [2:0] run_instruction();
      logic [15:0] start;
      logic [7:0]  opc;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [15:0] ad;
      logic [15:0] tmp;
      logic [7:0]  v;
      logic [4:0]  f;
      start = cpu_pc;
      opc = fetch_byte();
      dst = opc[5:3];
      src = opc[2:0];
      if (opc[7:6] == 2'b01 && opc != cse_pkg::OP_HLT) begin
         write_operand(dst, read_operand(src));
         return (dst == cse_pkg::CODE_M || src == cse_pkg::CODE_M) ? 3'd2 : 3'd1;
      end
      if (opc[7:5] == 3'b100) begin
         accumulate(dst[1:0], read_operand(src));
         return (src == cse_pkg::CODE_M) ? 3'd2 : 3'd1;
      end
      if (opc[7:6] == 2'b00 && src == 3'd6) begin
         write_operand(dst, fetch_byte());
         return (dst == cse_pkg::CODE_M) ? 3'd3 : 3'd2;
      end
      if (opc[7:6] == 2'b00 && src == 3'd4) begin
         v = read_operand(dst);
         f = szp_flags(v + 8'd1);
         f[0] = cpu_flags[0];
         f[2] = (v[3:0] == 4'hF);
         cpu_flags = f;
         write_operand(dst, v + 8'd1);
         return (dst == cse_pkg::CODE_M) ? 3'd3 : 3'd1;
      end
      case (opc)
         cse_pkg::OP_NOP: return 3'd1;
         cse_pkg::OP_ADI: begin accumulate(2'd0, fetch_byte()); return 3'd2; end
         cse_pkg::OP_ACI: begin accumulate(2'd1, fetch_byte()); return 3'd2; end
         cse_pkg::OP_SUI: begin accumulate(2'd2, fetch_byte()); return 3'd2; end
         cse_pkg::OP_SBI: begin accumulate(2'd3, fetch_byte()); return 3'd2; end
         cse_pkg::OP_LXIB: begin
            {cpu_regs[cse_pkg::RB], cpu_regs[cse_pkg::RC]} = fetch_word();
            return 3'd3;
         end
         cse_pkg::OP_LXID: begin
            {cpu_regs[cse_pkg::RD], cpu_regs[cse_pkg::RE]} = fetch_word();
            return 3'd3;
         end
         cse_pkg::OP_LXIH: begin
            {cpu_regs[cse_pkg::RH], cpu_regs[cse_pkg::RL]} = fetch_word();
            return 3'd3;
         end
         cse_pkg::OP_LXIS: begin cpu_sp = fetch_word(); return 3'd3; end
         cse_pkg::OP_LDXB: begin
            cpu_regs[cse_pkg::RA] = cpu_mem[reg_pair(cse_pkg::RB, cse_pkg::RC)];
            return 3'd2;
         end
         cse_pkg::OP_LDXD: begin
            cpu_regs[cse_pkg::RA] = cpu_mem[reg_pair(cse_pkg::RD, cse_pkg::RE)];
            return 3'd2;
         end
         cse_pkg::OP_LDA: begin
            cpu_regs[cse_pkg::RA] = cpu_mem[fetch_word()];
            return 3'd4;
         end
         cse_pkg::OP_STXB: begin
            cpu_mem[reg_pair(cse_pkg::RB, cse_pkg::RC)] = cpu_regs[cse_pkg::RA];
            return 3'd2;
         end
         cse_pkg::OP_STXD: begin
            cpu_mem[reg_pair(cse_pkg::RD, cse_pkg::RE)] = cpu_regs[cse_pkg::RA];
            return 3'd2;
         end
         cse_pkg::OP_STA: begin
            cpu_mem[fetch_word()] = cpu_regs[cse_pkg::RA];
            return 3'd4;
         end
         cse_pkg::OP_LHLD: begin
            ad = fetch_word();
            cpu_regs[cse_pkg::RL] = cpu_mem[ad];
            cpu_regs[cse_pkg::RH] = cpu_mem[ad + 16'd1];
            return 3'd5;
         end
         cse_pkg::OP_SHLD: begin
            ad = fetch_word();
            cpu_mem[ad] = cpu_regs[cse_pkg::RL];
            cpu_mem[ad + 16'd1] = cpu_regs[cse_pkg::RH];
            return 3'd5;
         end
         cse_pkg::OP_XCHG: begin
            tmp = reg_pair(cse_pkg::RH, cse_pkg::RL);
            {cpu_regs[cse_pkg::RH], cpu_regs[cse_pkg::RL]} = reg_pair(cse_pkg::RD, cse_pkg::RE);
            {cpu_regs[cse_pkg::RD], cpu_regs[cse_pkg::RE]} = tmp;
            return 3'd1;
         end
         default: begin
            cpu_pc = start;
            return 3'd0;
         end
      endcase
   endfunction

   function automatic cse_pkg::rsp_word_type predict_word(input logic opc,
                                                          input logic [15:0] addr,
                                                          input logic [7:0] data);
      cse_pkg::rsp_word_type w;
      logic [1:0] st;
      logic [2:0] cost;
      st = cse_pkg::ST_OK;
      cost = 3'd0;
      if (!opc) begin
         cpu_mem[addr] = data;
      end else if (cpu_halted) begin
         st = cse_pkg::ST_HALTED;
      end else begin
         cost = run_instruction();
         if (cost == 3'd0) begin
            cpu_halted = 1'b1;
            st = cse_pkg::ST_UNIMPL;
         end
      end
      w.out_a = cpu_regs[cse_pkg::RA];
      w.out_b = cpu_regs[cse_pkg::RB];
      w.out_c = cpu_regs[cse_pkg::RC];
      w.out_d = cpu_regs[cse_pkg::RD];
      w.out_e = cpu_regs[cse_pkg::RE];
      w.out_h = cpu_regs[cse_pkg::RH];
      w.out_l = cpu_regs[cse_pkg::RL];
      w.out_flags = cpu_flags;
      w.out_sp = cpu_sp;
      w.out_pc = cpu_pc;
      w.status = st;
      w.cycle_cost = cost;
      return w;
   endfunction

   // Sends one word and waits for its acceptance. The sender may idle first.
   // valid stays high between back-to-back words; it is never dropped and
   // raised inside the same time step.
   task automatic send_word(input logic opc, input logic [15:0] addr,
                            input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= opc;
      req_chan.load_addr <= addr;
      req_chan.load_data <= data;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pending_rsp.push_back(predict_word(opc, addr, data));
      words_sent++;
   endtask

   task automatic load_byte(input logic [15:0] addr, input logic [7:0] data);
      send_word(1'b0, addr, data);
   endtask

   task automatic step_cpu();
      send_word(1'b1, 16'd0, 8'd0);
   endtask

   task automatic idle_sender();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every owed response word has come back.
   task automatic drain();
      idle_sender();
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Receiver: stalls at random, and checks each accepted word against the
   // oldest expectation. Sampling happens on the clock edge, driving after it.
   initial begin
      cse_pkg::rsp_word_type exp_w;
      cse_pkg::rsp_word_type got;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.word;
            if (pending_rsp.size() == 0) begin
               $error("response word with nothing expected: %p", got);
               fail_count++;
            end else begin
               exp_w = pending_rsp.pop_front();
               words_checked++;
               if (got.status == cse_pkg::ST_UNIMPL)
                  halt_count++;
               if (got.out_a !== exp_w.out_a) begin
                  $error("out_a expected %h got %h", exp_w.out_a, got.out_a);
                  fail_count++;
               end
               if (got.out_b !== exp_w.out_b) begin
                  $error("out_b expected %h got %h", exp_w.out_b, got.out_b);
                  fail_count++;
               end
               if (got.out_c !== exp_w.out_c) begin
                  $error("out_c expected %h got %h", exp_w.out_c, got.out_c);
                  fail_count++;
               end
               if (got.out_d !== exp_w.out_d) begin
                  $error("out_d expected %h got %h", exp_w.out_d, got.out_d);
                  fail_count++;
               end
               if (got.out_e !== exp_w.out_e) begin
                  $error("out_e expected %h got %h", exp_w.out_e, got.out_e);
                  fail_count++;
               end
               if (got.out_h !== exp_w.out_h) begin
                  $error("out_h expected %h got %h", exp_w.out_h, got.out_h);
                  fail_count++;
               end
               if (got.out_l !== exp_w.out_l) begin
                  $error("out_l expected %h got %h", exp_w.out_l, got.out_l);
                  fail_count++;
               end
               if (got.out_flags !== exp_w.out_flags) begin
                  $error("out_flags expected %h got %h", exp_w.out_flags, got.out_flags);
                  fail_count++;
               end
               if (got.out_sp !== exp_w.out_sp) begin
                  $error("out_sp expected %h got %h", exp_w.out_sp, got.out_sp);
                  fail_count++;
               end
               if (got.out_pc !== exp_w.out_pc) begin
                  $error("out_pc expected %h got %h", exp_w.out_pc, got.out_pc);
                  fail_count++;
               end
               if (got.status !== exp_w.status) begin
                  $error("status expected %0d got %0d", exp_w.status, got.status);
                  fail_count++;
               end
               if (got.cycle_cost !== exp_w.cycle_cost) begin
                  $error("cycle_cost expected %0d got %0d", exp_w.cycle_cost,
                         got.cycle_cost);
                  fail_count++;
               end
            end
         end
      end
   end

   // Directed table. A row either loads a byte or steps the core. Where the
   // expected status or cost is obvious it is typed in and checked against
   // the predictor's own answer as well; a wildcard value of 3'h7 / 2'h3
   // means the row relies on the predictor alone.
   typedef struct {
      logic        opc;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [1:0]  want_status;
      logic [2:0]  want_cost;
   } stim_row_type;

   localparam logic [1:0] ANY_ST   = 2'd3;
   localparam logic [2:0] ANY_COST = 3'd7;

   stim_row_type stim_table [24] = '{
      // Reset state: memory is zero, so PC 0 holds NOP.
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd1},
      // Program at 0x0001: MVI A,FF ; ADI 01 (zero, carry, half carry).
      '{1'b0, 16'h0001, 8'h3E, ANY_ST, 3'd0},
      '{1'b0, 16'h0002, 8'hFF, ANY_ST, 3'd0},
      '{1'b0, 16'h0003, cse_pkg::OP_ADI, ANY_ST, 3'd0},
      '{1'b0, 16'h0004, 8'h01, ANY_ST, 3'd0},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd2},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd2},
      // LXI H,FFFF ; MVI M,7F ; INR M ; SHLD FFFF (address wrap at the top).
      '{1'b0, 16'h0005, cse_pkg::OP_LXIH, ANY_ST, 3'd0},
      '{1'b0, 16'h0006, 8'hFF, ANY_ST, 3'd0},
      '{1'b0, 16'h0007, 8'hFF, ANY_ST, 3'd0},
      '{1'b0, 16'h0008, 8'h36, ANY_ST, 3'd0},
      '{1'b0, 16'h0009, 8'h7F, ANY_ST, 3'd0},
      '{1'b0, 16'h000A, 8'h34, ANY_ST, 3'd0},
      '{1'b0, 16'h000B, cse_pkg::OP_SHLD, ANY_ST, 3'd0},
      '{1'b0, 16'h000C, 8'hFF, ANY_ST, 3'd0},
      '{1'b0, 16'h000D, 8'hFF, ANY_ST, 3'd0},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd3},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd3},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd3},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_OK, 3'd5},
      // HLT: unimplemented, then already halted; a load still lands.
      '{1'b0, 16'h000E, cse_pkg::OP_HLT, ANY_ST, 3'd0},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_UNIMPL, 3'd0},
      '{1'b1, 16'h0000, 8'h00, cse_pkg::ST_HALTED, 3'd0},
      '{1'b0, 16'hFFFF, 8'hFF, cse_pkg::ST_OK, 3'd0}
   };

   // Random program generation. Most of the memory near PC is filled with
   // legal instructions carrying random operands; a few stray opcodes and
   // random loads are mixed in as noise.
   function automatic logic [7:0] pick_opcode();
      int sel;
      logic [7:0] mv;
      sel = $urandom_range(99);
      mv  = {2'b01, 6'($urandom_range(63))};
      if (sel < 25) return (mv == cse_pkg::OP_HLT) ? cse_pkg::OP_NOP : mv;
      if (sel < 45) return {3'b100, 5'($urandom_range(31))};
      if (sel < 55) return {2'b00, 3'($urandom_range(7)), 3'd6};
      if (sel < 63) return {2'b00, 3'($urandom_range(7)), 3'd4};
      if (sel < 98) begin
         case ($urandom_range(18))
            0: return cse_pkg::OP_NOP;
            1: return cse_pkg::OP_ADI;
            2: return cse_pkg::OP_ACI;
            3: return cse_pkg::OP_SUI;
            4: return cse_pkg::OP_SBI;
            5: return cse_pkg::OP_LXIB;
            6: return cse_pkg::OP_LXID;
            7: return cse_pkg::OP_LXIH;
            8: return cse_pkg::OP_LXIS;
            9: return cse_pkg::OP_LDXB;
            10: return cse_pkg::OP_LDXD;
            11: return cse_pkg::OP_LDA;
            12: return cse_pkg::OP_STXB;
            13: return cse_pkg::OP_STXD;
            14: return cse_pkg::OP_STA;
            15: return cse_pkg::OP_LHLD;
            16: return cse_pkg::OP_SHLD;
            default: return cse_pkg::OP_XCHG;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   // Writes a fresh instruction with random operand bytes at the current
   // predicted PC, then executes it.
   task automatic run_random_instruction();
      logic [15:0] at;
      at = cpu_pc;
      load_byte(at, pick_opcode());
      load_byte(at + 16'd1, 8'($urandom_range(255)));
      load_byte(at + 16'd2, 8'($urandom_range(255)));
      step_cpu();
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
         default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
   endtask

   initial begin
      cse_pkg::rsp_word_type w;
      int n;
      fail_count     = 0;
      words_sent     = 0;
      words_checked  = 0;
      halt_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 7; i++)
         cpu_regs[i] = 8'd0;
      cpu_flags  = 5'd0;
      cpu_sp     = 16'd0;
      cpu_pc     = 16'd0;
      cpu_halted = 1'b0;
      for (int i = 0; i < 65536; i++)
         cpu_mem[i] = 8'd0;

      reset <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= 1'b0;
      req_chan.load_addr <= 16'd0;
      req_chan.load_data <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The typed-in status and cost are compared with the
      // predictor's answer so that a predictor slip is caught too.
      foreach (stim_table[i]) begin
         send_word(stim_table[i].opc, stim_table[i].addr, stim_table[i].data);
         w = pending_rsp[$];
         if (stim_table[i].want_status != ANY_ST &&
             w.status !== stim_table[i].want_status) begin
            $error("status expected %0d got %0d", stim_table[i].want_status, w.status);
            fail_count++;
         end
         if (stim_table[i].want_cost != ANY_COST &&
             w.cycle_cost !== stim_table[i].want_cost) begin
            $error("cycle_cost expected %0d got %0d", stim_table[i].want_cost,
                   w.cycle_cost);
            fail_count++;
         end
      end
      drain();

      // Random part. The core stays halted after its first stray opcode; from
      // then on the remaining words load random bytes or step the halted core.
      n = 0;
      while (words_sent < 450) begin
         if (n % 30 == 0) begin
            drain();
            set_idling(n / 30);
         end
         if (cpu_halted) begin
            if ($urandom_range(1))
               load_byte(16'($urandom_range(65535)), 8'($urandom_range(255)));
            else
               step_cpu();
         end else if ($urandom_range(99) < 90) begin
            run_random_instruction();
         end else begin
            load_byte(16'($urandom_range(65535)), 8'($urandom_range(255)));
         end
         n++;
      end
      set_idling(0);
      drain();

      $display("Covered %0d words with %0d responses checked; %0d halts seen.",
               words_sent, words_checked, halt_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/cse_pkg.sv
hdl/cse_if.sv
hdl/cse_ram.sv
hdl/cpu8080_subset_execute_unit.sv
tb/sv/tb_cpu8080_subset_execute_unit.sv
